>>> design/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants of the plus-stencil bright spot counter.
// ----------------------------------------------------------------------------
package sbc_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_COLUMNS_DEFAULT = 1024;
  localparam int PIXEL_BITS_DEFAULT  = 8;

  // Frame geometry
  localparam int MAX_ROWS  = 1024;
  localparam int ROW_BITS  = 10;
  localparam int SIZE_BITS = 11;

  // Size register reset values
  localparam logic [SIZE_BITS-1:0] ROWS_RESET    = 11'd3;
  localparam logic [SIZE_BITS-1:0] COLUMNS_RESET = 11'd3;

  // Counting
  localparam int                   COUNT_BITS    = 20;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = 20'hFFFFF;
  localparam int                   SUM_THRESHOLD = 30;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_ROWS    = 1'b0,
    REG_IMAGE_COLUMNS = 1'b1
  } cfg_reg_t;

  // Per-transaction status from the frame controller to the datapath
  typedef struct packed {
    logic interior;   // centre of this column is an interior pixel
    logic frame_end;  // this transaction is the last pixel of the frame
    logic byp_same;   // prefetched column was the one just written
    logic byp_right;  // prefetched right neighbour was the one just written
  } step_t;

endpackage

>>> design/sbc_pixel_if.sv
// ----------------------------------------------------------------------------
// sbc_pixel_if
// Valid/ready stream carrying one pixel per transaction.
// ----------------------------------------------------------------------------
interface sbc_pixel_if #(
  parameter int PIXEL_BITS = sbc_pkg::PIXEL_BITS_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

>>> design/sbc_count_if.sv
// ----------------------------------------------------------------------------
// sbc_count_if
// Valid/ready stream carrying one frame count per transaction.
// ----------------------------------------------------------------------------
interface sbc_count_if;
  logic                           valid;
  logic                           ready;
  logic [sbc_pkg::COUNT_BITS-1:0] star_count;

  modport source (output valid, output star_count, input ready);
  modport sink   (input valid, input star_count, output ready);
endinterface

>>> design/sbc_line_store.sv
// ----------------------------------------------------------------------------
// sbc_line_store
// One-row line store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sbc_line_store #(
  parameter int DEPTH = sbc_pkg::MAX_COLUMNS_DEFAULT,
  parameter int WIDTH = sbc_pkg::PIXEL_BITS_DEFAULT,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port (old data on a same-address write)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/sbc_frame_ctrl.sv
// ----------------------------------------------------------------------------
// sbc_frame_ctrl
// Size registers, row/column position counters, line store read-ahead
// addresses and bypass flags.
// ----------------------------------------------------------------------------
module sbc_frame_ctrl #(
  parameter int MAX_COLUMNS = sbc_pkg::MAX_COLUMNS_DEFAULT,
  localparam int AW         = $clog2(MAX_COLUMNS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sbc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sbc_pkg::SIZE_BITS-1:0]      cfg_data,
  input  logic                               accept,
  output sbc_pkg::step_t                     step,
  output logic [AW-1:0]                      col,
  output logic [AW-1:0]                      rd_addr_same,
  output logic [AW-1:0]                      rd_addr_right
);

  // Wide enough for the clamped column count and position + 2
  localparam int XW = (AW + 2 > sbc_pkg::SIZE_BITS) ? AW + 2 : sbc_pkg::SIZE_BITS;
  localparam int SW = sbc_pkg::SIZE_BITS;

  logic [SW-1:0]                image_rows;
  logic [SW-1:0]                image_columns;
  logic [sbc_pkg::ROW_BITS-1:0] row;
  logic [sbc_pkg::ROW_BITS-1:0] row_next;
  logic [AW-1:0]                col_next;
  logic                         byp_same;
  logic                         byp_right;

  logic [SW-1:0] rows_eff;
  logic [XW-1:0] cols_cfg_x;
  logic [XW-1:0] cols_eff;
  logic [XW-1:0] col_x;
  logic [XW-1:0] col_next_x;
  logic [SW-1:0] row_x;
  logic          col_end;
  logic          row_end;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows    <= sbc_pkg::ROWS_RESET;
      image_columns <= sbc_pkg::COLUMNS_RESET;
    end else if (cfg_write) begin
      case (sbc_pkg::cfg_reg_t'(cfg_index))
        sbc_pkg::REG_IMAGE_ROWS:    image_rows    <= cfg_data;
        sbc_pkg::REG_IMAGE_COLUMNS: image_columns <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped sizes and position decode
  always_comb begin
    if (image_rows == '0) begin
      rows_eff = SW'(1);
    end else if (image_rows > SW'(sbc_pkg::MAX_ROWS)) begin
      rows_eff = SW'(sbc_pkg::MAX_ROWS);
    end else begin
      rows_eff = image_rows;
    end

    cols_cfg_x = XW'(image_columns);
    if (cols_cfg_x == '0) begin
      cols_eff = XW'(1);
    end else if (cols_cfg_x > XW'(MAX_COLUMNS)) begin
      cols_eff = XW'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_cfg_x;
    end

    col_x   = XW'(col);
    row_x   = SW'(row);
    col_end = (col_x + XW'(1)) >= cols_eff;
    row_end = (row_x + SW'(1)) >= rows_eff;

    step.interior  = (row >= sbc_pkg::ROW_BITS'(2)) && ((row_x + SW'(1)) <= rows_eff) &&
                     (col != '0) && ((col_x + XW'(2)) <= cols_eff);
    step.frame_end = col_end && row_end;
    step.byp_same  = byp_same;
    step.byp_right = byp_right;

    col_next = col_end ? '0 : AW'(col_x + XW'(1));
    if (!col_end) begin
      row_next = row;
    end else if (row_end) begin
      row_next = '0;
    end else begin
      row_next = sbc_pkg::ROW_BITS'(row_x + SW'(1));
    end

    // Read ahead at the next transaction's column and its right neighbour
    col_next_x    = XW'(col_next);
    rd_addr_same  = col_next;
    rd_addr_right = ((col_next_x + XW'(1)) < XW'(MAX_COLUMNS)) ?
                    AW'(col_next_x + XW'(1)) : '0;
  end

  // Position counters and bypass flags
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      byp_same  <= 1'b0;
      byp_right <= 1'b0;
    end else if (accept) begin
      col       <= col_next;
      row       <= row_next;
      byp_same  <= (col_next == col);
      byp_right <= ((col_next_x + XW'(1)) == col_x);
    end
  end

endmodule

>>> design/plus_stencil_bright_spot_counter.sv
// ----------------------------------------------------------------------------
// plus_stencil_bright_spot_counter
// Counts interior pixels of a raster frame whose five-point plus sum > 30.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle in raster order, stalling only as described
// below: the five-point sum, the threshold compare and the saturating
// counter update all happen in the cycle the pixel is taken, with the line
// stores read one column ahead so their registered data is ready when the
// next pixel arrives. The frame count appears on the count stream in the
// cycle after the frame's last pixel is taken; the pixel stream only stalls
// when a frame's last pixel arrives while the previous count still waits to
// be taken. Frame size comes from the image_rows and image_columns registers
// (0 acts as 1, values above 1024 rows or MAX_COLUMNS columns are clamped);
// write them between frames. Line stores need no clearing after reset.
// ----------------------------------------------------------------------------
module plus_stencil_bright_spot_counter #(
  parameter int MAX_COLUMNS = sbc_pkg::MAX_COLUMNS_DEFAULT,
  parameter int PIXEL_BITS  = sbc_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sbc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sbc_pkg::SIZE_BITS-1:0]      cfg_data,
  sbc_pixel_if.sink                          pixels,
  sbc_count_if.source                        counts
);

  localparam int AW   = $clog2(MAX_COLUMNS);
  localparam int SUMW = (PIXEL_BITS + 3 > 5) ? PIXEL_BITS + 3 : 5;
  localparam int CB   = sbc_pkg::COUNT_BITS;

  sbc_pkg::step_t        step;
  logic [AW-1:0]         col;
  logic [AW-1:0]         rd_addr_same;
  logic [AW-1:0]         rd_addr_right;
  logic                  accept;

  logic [PIXEL_BITS-1:0] prev_same_rd;
  logic [PIXEL_BITS-1:0] prev_right_rd;
  logic [PIXEL_BITS-1:0] older_rd;
  logic [PIXEL_BITS-1:0] px_q;
  logic [PIXEL_BITS-1:0] centre_q;
  logic [PIXEL_BITS-1:0] left_hold;
  logic [PIXEL_BITS-1:0] centre;
  logic [PIXEL_BITS-1:0] upper;
  logic [PIXEL_BITS-1:0] right;
  logic [SUMW-1:0]       sum;
  logic                  pass;

  logic [CB-1:0]         running_count;
  logic [CB-1:0]         count_next;
  logic                  count_valid;
  logic [CB-1:0]         star_count;

  // Handshake: only a frame-ending pixel waits on a pending count
  assign pixels.ready     = !count_valid || counts.ready || !step.frame_end;
  assign accept           = pixels.valid && pixels.ready;
  assign counts.valid     = count_valid;
  assign counts.star_count = star_count;

  sbc_frame_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .step          (step),
    .col           (col),
    .rd_addr_same  (rd_addr_same),
    .rd_addr_right (rd_addr_right)
  );

  // Row r-1, read at the centre column
  sbc_line_store #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (PIXEL_BITS)
  ) u_prev_same (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (pixels.pixel),
    .rd_en   (accept),
    .rd_addr (rd_addr_same),
    .rd_data (prev_same_rd)
  );

  // Row r-1 copy, read at the right neighbour column
  sbc_line_store #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (PIXEL_BITS)
  ) u_prev_right (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (pixels.pixel),
    .rd_en   (accept),
    .rd_addr (rd_addr_right),
    .rd_data (prev_right_rd)
  );

  // Row r-2
  sbc_line_store #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (PIXEL_BITS)
  ) u_older (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (centre),
    .rd_en   (accept),
    .rd_addr (rd_addr_same),
    .rd_data (older_rd)
  );

  // Forward the last writes when the read-ahead hit the written column
  always_comb begin
    centre = step.byp_same  ? px_q     : prev_same_rd;
    upper  = step.byp_same  ? centre_q : older_rd;
    right  = step.byp_right ? px_q     : prev_right_rd;
    sum    = SUMW'(centre) + SUMW'(left_hold) + SUMW'(right) + SUMW'(upper) +
             SUMW'(pixels.pixel);
    pass   = sum > SUMW'(sbc_pkg::SUM_THRESHOLD);
    count_next = running_count;
    if (step.interior && pass && (running_count != sbc_pkg::COUNT_MAX)) begin
      count_next = running_count + CB'(1);
    end
  end

  // Window holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_q      <= pixels.pixel;
      centre_q  <= centre;
      left_hold <= centre;
    end
  end

  // Running count
  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
    end else if (accept) begin
      running_count <= step.frame_end ? '0 : count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else if (accept && step.frame_end) begin
      count_valid <= 1'b1;
    end else if (counts.ready) begin
      count_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step.frame_end) begin
      star_count <= count_next;
    end
  end

endmodule
